// ===== rtl/lpfp_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types and constants for the length-prefixed frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LengthW = 32;
  localparam int unsigned LenCntW = 2;

  localparam logic [LenCntW-1:0] LenCntLast = LenCntW'(LengthW / ByteW - 1);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_COMMAND = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_DATA    = 3'd4
  } lpfp_phase_e;

endpackage

`default_nettype wire

// ===== rtl/lpfp_if.sv =====
// ----------------------------------------------------------------------------
// lpfp_if
// Valid/ready channels of the frame parser: received bytes, results and
// the start byte register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfp_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  command;
  logic [7:0]  msg_type;
  logic [31:0] frame_length;
  logic [7:0]  payload_byte;
  logic        has_payload;
  logic        last;

  modport source (output valid, output command, output msg_type, output frame_length,
                  output payload_byte, output has_payload, output last, input ready);
  modport sink   (input valid, input command, input msg_type, input frame_length,
                  input payload_byte, input has_payload, input last, output ready);
endinterface

interface lpfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] start_byte;

  modport source (output valid, output start_byte, input ready);
  modport sink   (input valid, input start_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/length_prefixed_frame_parser.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Hunts for the start byte, collects command, type and a four-byte
// little-endian length, then streams the payload bytes out with the header.
//
//   channel  direction  payload                                   handshake
//   rx_if    in         rx_byte                                   valid/ready
//   res_if   out        command msg_type frame_length payload_byte valid/ready
//                       has_payload last
//   cfg_if   in         start_byte                                valid/ready
//
// One byte per cycle while results are taken; a byte passes through the input
// register, then the result register. Header and idle bytes give no result,
// except the last length byte of an empty frame. rst_ni clears phase, counts
// and the valid flags; start_byte resets to zero. A stalled result holds the
// result register; the input register takes one more byte, then ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lpfp_rx_if.sink   rx_if,
  lpfp_res_if.source res_if,
  lpfp_cfg_if.sink  cfg_if
);
  import lpfp_pkg::*;

  logic [ByteW-1:0]   start_byte_q;
  logic               in_valid_q, in_valid_d;
  logic [ByteW-1:0]   in_byte_q;
  lpfp_phase_e        phase_q, phase_d;
  logic [ByteW-1:0]   cmd_q, cmd_d;
  logic [ByteW-1:0]   typ_q, typ_d;
  logic [LengthW-1:0] len_q, len_d;
  logic [LenCntW-1:0] len_cnt_q, len_cnt_d;
  logic [LengthW-1:0] rcv_q, rcv_d;

  logic               out_valid_q, out_valid_d;
  logic [ByteW-1:0]   out_cmd_q, out_typ_q, out_pay_q;
  logic [LengthW-1:0] out_len_q;
  logic               out_has_q, out_last_q;

  logic               advance, process, emit, emit_has, emit_last;
  logic [ByteW-1:0]   emit_pay;
  logic [LengthW-1:0] len_next, rcv_next;

  assign advance      = !out_valid_q || res_if.ready;
  assign process      = in_valid_q && advance;
  assign rx_if.ready  = !in_valid_q || advance;
  assign cfg_if.ready = 1'b1;

  assign len_next = len_q | ({{(LengthW-ByteW){1'b0}}, in_byte_q} << {len_cnt_q, 3'b000});
  assign rcv_next = rcv_q + LengthW'(1);

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    typ_d     = typ_q;
    len_d     = len_q;
    len_cnt_d = len_cnt_q;
    rcv_d     = rcv_q;
    emit      = 1'b0;
    emit_pay  = '0;
    emit_has  = 1'b0;
    emit_last = 1'b0;
    if (process) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (in_byte_q == start_byte_q) begin
            cmd_d     = '0;
            typ_d     = '0;
            len_d     = '0;
            len_cnt_d = '0;
            rcv_d     = '0;
            phase_d   = PH_COMMAND;
          end
        end
        PH_COMMAND: begin
          cmd_d   = in_byte_q;
          phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          typ_d   = in_byte_q;
          phase_d = PH_LENGTH;
        end
        PH_LENGTH: begin
          len_d = len_next;
          if (len_cnt_q == LenCntLast) begin
            len_cnt_d = '0;
            rcv_d     = '0;
            if (len_next == '0) begin
              phase_d   = PH_IDLE;
              emit      = 1'b1;
              emit_last = 1'b1;
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            len_cnt_d = len_cnt_q + LenCntW'(1);
          end
        end
        PH_DATA: begin
          rcv_d     = rcv_next;
          emit      = 1'b1;
          emit_pay  = in_byte_q;
          emit_has  = 1'b1;
          emit_last = (rcv_next == len_q);
          if (rcv_next == len_q) begin
            phase_d = PH_IDLE;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_if.valid && rx_if.ready) begin
      in_valid_d = 1'b1;
    end else if (process) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= '0;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PH_IDLE;
      cmd_q        <= '0;
      typ_q        <= '0;
      len_q        <= '0;
      len_cnt_q    <= '0;
      rcv_q        <= '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        start_byte_q <= cfg_if.start_byte;
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      cmd_q       <= cmd_d;
      typ_q       <= typ_d;
      len_q       <= len_d;
      len_cnt_q   <= len_cnt_d;
      rcv_q       <= rcv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_if.valid && rx_if.ready) begin
      in_byte_q <= rx_if.rx_byte;
    end
    if (advance && emit) begin
      out_cmd_q  <= cmd_d;
      out_typ_q  <= typ_d;
      out_len_q  <= len_d;
      out_pay_q  <= emit_pay;
      out_has_q  <= emit_has;
      out_last_q <= emit_last;
    end
  end

  assign res_if.valid        = out_valid_q;
  assign res_if.command      = out_cmd_q;
  assign res_if.msg_type     = out_typ_q;
  assign res_if.frame_length = out_len_q;
  assign res_if.payload_byte = out_pay_q;
  assign res_if.has_payload  = out_has_q;
  assign res_if.last         = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/lpfp_checker.sv =====
// ----------------------------------------------------------------------------
// lpfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        rx_ready_i,
  input wire logic        res_valid_i,
  input wire logic        res_ready_i,
  input wire logic [7:0]  res_command_i,
  input wire logic [7:0]  res_msg_type_i,
  input wire logic [31:0] res_frame_length_i,
  input wire logic [7:0]  res_payload_byte_i,
  input wire logic        res_has_payload_i,
  input wire logic        res_last_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_command_i)
      && $stable(res_msg_type_i) && $stable(res_frame_length_i)
      && $stable(res_payload_byte_i) && $stable(res_has_payload_i) && $stable(res_last_i))
    else $error("result request changed while stalled");

  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_has_payload_i |-> res_last_i && res_payload_byte_i == 8'd0)
    else $error("empty-frame result without last or with payload");

  a_len_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_has_payload_i == (res_frame_length_i != 32'd0))
    else $error("has_payload disagrees with frame length");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_i |-> res_valid_i && !res_ready_i)
    else $error("input stalled while result side is free");

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rx_ready_i         (rx_if.ready),
  .res_valid_i        (res_if.valid),
  .res_ready_i        (res_if.ready),
  .res_command_i      (res_if.command),
  .res_msg_type_i     (res_if.msg_type),
  .res_frame_length_i (res_if.frame_length),
  .res_payload_byte_i (res_if.payload_byte),
  .res_has_payload_i  (res_if.has_payload),
  .res_last_i         (res_if.last)
);

`default_nettype wire

// ===== sim/length_prefixed_frame_parser_tb.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_tb
// Self-checking bench for the frame parser. Drives a byte stream of
// well-formed frames with noise between them and start bytes buried inside
// headers and payloads. Each result beat is predicted in the bench and
// compared field by field with the result channel. The start byte register
// is reprogrammed between phases. Both sides idle at random. The receiver
// holds off for a long stretch while an endless frame is streamed in.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_parser_tb;
  import lpfp_pkg::*;

  typedef struct packed {
    logic [7:0]  command;
    logic [7:0]  msg_type;
    logic [31:0] frame_length;
    logic [7:0]  payload_byte;
    logic        has_payload;
    logic        last;
  } frame_beat_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        chk;
    frame_beat_t beat;
  } dir_row_t;

  localparam int          IdleLimit = 2000;
  localparam int          HoldCycles = 80;
  localparam int          NumPhases = 6;
  localparam int          PhaseBytes = 310;
  localparam frame_beat_t NoBeat = '0;

  localparam logic [7:0] StartVals [NumPhases] = '{8'hFF, 8'h00, 8'h7E, 8'h5A, 8'h80, 8'h01};

  localparam dir_row_t DirRows [26] = '{
    '{8'h55, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{8'hFF, 8'h00, 32'd0, 8'h00, 1'b0, 1'b1}},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h03, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'hFF, 1'b1, '{8'h00, 8'hFF, 32'd3, 8'hFF, 1'b1, 1'b1}},
    '{8'h00, 1'b0, '0},
    '{8'hA5, 1'b0, '0},
    '{8'h5A, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{8'hA5, 8'h5A, 32'd1, 8'h00, 1'b1, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst_n;

  lpfp_rx_if  rx_if ();
  lpfp_res_if res_if ();
  lpfp_cfg_if cfg_if ();

  length_prefixed_frame_parser u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_if  (rx_if),
    .res_if (res_if),
    .cfg_if (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser model state
  lpfp_phase_e  ph;
  logic [7:0]   sb_model;
  logic [7:0]   hcmd;
  logic [7:0]   htyp;
  logic [31:0]  hlen;
  logic [1:0]   lcnt;
  logic [31:0]  rcnt;

  frame_beat_t  beats_due [$];
  int           mismatches;
  int           bytes_sent;
  int           idle_cycles;
  logic [7:0]   cur_start;
  logic         no_idle;
  logic         hold_req;
  logic         stim_chk;
  frame_beat_t  stim_exp;

  function automatic bit parse_byte(input logic [7:0] data, output frame_beat_t beat);
    beat = '0;
    parse_byte = 1'b0;
    case (ph)
      PH_IDLE: begin
        if (data == sb_model) begin
          hcmd = '0;
          htyp = '0;
          hlen = '0;
          lcnt = '0;
          rcnt = '0;
          ph = PH_COMMAND;
        end
      end
      PH_COMMAND: begin
        hcmd = data;
        ph = PH_TYPE;
      end
      PH_TYPE: begin
        htyp = data;
        ph = PH_LENGTH;
      end
      PH_LENGTH: begin
        hlen = hlen | (32'(data) << (8 * lcnt));
        if (lcnt == LenCntLast) begin
          lcnt = '0;
          rcnt = '0;
          if (hlen == 32'd0) begin
            ph = PH_IDLE;
            beat = '{hcmd, htyp, hlen, 8'h00, 1'b0, 1'b1};
            parse_byte = 1'b1;
          end else begin
            ph = PH_DATA;
          end
        end else begin
          lcnt = lcnt + 2'd1;
        end
      end
      PH_DATA: begin
        rcnt = rcnt + 32'd1;
        beat = '{hcmd, htyp, hlen, data, 1'b1, rcnt == hlen};
        if (rcnt == hlen) ph = PH_IDLE;
        parse_byte = 1'b1;
      end
      default: ph = PH_IDLE;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_beat_t beat;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb_model = cfg_if.start_byte;
      if (rx_if.valid && rx_if.ready) begin
        if (parse_byte(rx_if.rx_byte, beat) || stim_chk)
          beats_due.push_back(stim_chk ? stim_exp : beat);
      end
      if (res_if.valid && res_if.ready) begin
        if (beats_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, payload_byte %0h last %0b", $time,
                   res_if.payload_byte, res_if.last);
        end else begin
          beat = beats_due.pop_front();
          check_field("command", 32'(beat.command), 32'(res_if.command));
          check_field("msg_type", 32'(beat.msg_type), 32'(res_if.msg_type));
          check_field("frame_length", beat.frame_length, res_if.frame_length);
          check_field("payload_byte", 32'(beat.payload_byte), 32'(res_if.payload_byte));
          check_field("has_payload", 32'(beat.has_payload), 32'(res_if.has_payload));
          check_field("last", 32'(beat.last), 32'(res_if.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles == IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic chk, input frame_beat_t exp);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= data;
    stim_chk      <= chk;
    stim_exp      <= exp;
    do @(posedge clk); while (!rx_if.ready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] mix_byte();
    logic [7:0] data;
    data = 8'($urandom);
    return ($urandom_range(0, 7) == 0) ? cur_start : data;
  endfunction

  task automatic send_frame();
    logic [7:0]  noise;
    logic [31:0] len;
    int          pick;
    int          i;
    repeat ($urandom_range(0, 2)) begin
      noise = 8'($urandom);
      if (noise == cur_start) noise = ~noise;
      send_byte(noise, 1'b0, NoBeat);
    end
    send_byte(cur_start, 1'b0, NoBeat);
    send_byte(mix_byte(), 1'b0, NoBeat);
    send_byte(mix_byte(), 1'b0, NoBeat);
    pick = $urandom_range(0, 9);
    len = (pick < 2) ? 32'd0 : (pick < 9) ? $urandom_range(1, 8) : $urandom_range(9, 300);
    for (i = 0; i < 4; i++) send_byte(len[8*i +: 8], 1'b0, NoBeat);
    repeat (len) send_byte(mix_byte(), 1'b0, NoBeat);
  endtask

  task automatic settle();
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start(input logic [7:0] value);
    @(negedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.start_byte <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    cur_start = value;
  endtask

  initial begin : stimulus
    int p;
    int i;
    int target;
    rst_n             = 1'b0;
    rx_if.valid       = 1'b0;
    rx_if.rx_byte     = '0;
    res_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.start_byte = '0;
    stim_chk          = 1'b0;
    stim_exp          = '0;
    no_idle           = 1'b0;
    hold_req          = 1'b0;
    cur_start         = 8'h00;
    mismatches        = 0;
    bytes_sent        = 0;
    idle_cycles       = 0;
    ph                = PH_IDLE;
    sb_model          = 8'h00;
    hcmd              = '0;
    htyp              = '0;
    hlen              = '0;
    lcnt              = '0;
    rcnt              = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DirRows[i]) send_byte(DirRows[i].data, DirRows[i].chk, DirRows[i].beat);

    target = bytes_sent;
    for (p = 0; p < NumPhases; p++) begin
      settle();
      write_start(StartVals[p]);
      no_idle = (p == 2);
      target += PhaseBytes;
      while (bytes_sent < target) send_frame();
    end

    // endless frame: receiver holds off while payload keeps coming
    settle();
    write_start(8'($urandom_range(0, 255)));
    no_idle = 1'b1;
    send_byte(cur_start, 1'b0, NoBeat);
    send_byte(mix_byte(), 1'b0, NoBeat);
    send_byte(mix_byte(), 1'b0, NoBeat);
    for (i = 0; i < 4; i++) send_byte(8'hFF, 1'b0, NoBeat);
    hold_req = 1'b1;
    repeat (40) send_byte(mix_byte(), 1'b0, NoBeat);

    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== length_prefixed_frame_parser.f =====
rtl/lpfp_pkg.sv
rtl/lpfp_if.sv
rtl/length_prefixed_frame_parser.sv
rtl/lpfp_checker.sv
sim/length_prefixed_frame_parser_tb.sv
